[src/pdt_pkg.sv]
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared types, codes and defaults for the palette deduplication table.
// ----------------------------------------------------------------------------
package pdt_pkg;

    // default number of palette entries
    localparam int PALETTE_DEPTH_DEF = 256;

    // input modes
    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_ADDED = 3'd0,
        STAT_FOUND = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_RANGE = 3'd3,
        STAT_OK    = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RDWAIT,
        S_DONE
    } state_t;

    // one result item
    typedef struct packed {
        status_t     status;
        logic [7:0]  entry_index;
        logic [23:0] rgb;
        logic [8:0]  entry_count;
    } result_t;

    // palette memory strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // build a result item
    function automatic result_t make_result(status_t st, logic [7:0] idx,
                                            logic [23:0] rgb, logic [8:0] cnt);
        result_t r;
        r.status      = st;
        r.entry_index = idx;
        r.rgb         = rgb;
        r.entry_count = cnt;
        return r;
    endfunction

endpackage

[src/pdt_palette_ram.sv]
// ----------------------------------------------------------------------------
// pdt_palette_ram
// Colour store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pdt_palette_ram #(
    parameter int DEPTH = pdt_pkg::PALETTE_DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  pdt_pkg::mem_ctl_t ctl,
    input  logic [IDX_W-1:0]  raddr,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [23:0]       wdata,
    output logic [23:0]       rdata
);

    logic [23:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/pdt_seq.sv]
// ----------------------------------------------------------------------------
// pdt_seq
// Item sequencer: entry count, linear search over the colour store,
// append, read and clear handling.
// ----------------------------------------------------------------------------
module pdt_seq #(
    parameter int DEPTH = pdt_pkg::PALETTE_DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [7:0]         s_red,
    input  logic [7:0]         s_green,
    input  logic [7:0]         s_blue,
    input  logic [7:0]         s_read_index,
    output logic               res_valid,
    input  logic               res_ready,
    output pdt_pkg::result_t   res,
    output pdt_pkg::mem_ctl_t  mem_ctl,
    output logic [IDX_W-1:0]   mem_raddr,
    output logic [IDX_W-1:0]   mem_waddr,
    output logic [23:0]        mem_wdata,
    input  logic [23:0]        mem_rdata
);

    localparam int EXT_W = CNT_W + 8;
    localparam int PEXT_W = IDX_W + 8;

    pdt_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_ptr_reg, issue_ptr_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_addr_reg, pend_addr_next;
    logic [23:0]      color_reg, color_next;
    pdt_pkg::result_t res_reg, res_next;

    logic [EXT_W-1:0]  cnt_ext;
    logic [EXT_W-1:0]  cnt_inc_ext;
    logic [EXT_W-1:0]  ridx_ext;
    logic [PEXT_W-1:0] pend_ext;
    logic              issue_more;
    logic              hit;

    // widened views for compare and field truncation
    assign cnt_ext     = EXT_W'(count_reg);
    assign cnt_inc_ext = cnt_ext + EXT_W'(1);
    assign ridx_ext    = EXT_W'(s_read_index);
    assign pend_ext    = PEXT_W'(pend_addr_reg);
    assign issue_more  = (issue_ptr_reg < count_reg);
    assign hit         = pend_reg && (mem_rdata == color_reg);

    assign res       = res_reg;
    assign res_valid = (state_reg == pdt_pkg::S_DONE);
    assign mem_wdata = color_reg;
    assign mem_waddr = count_reg[IDX_W-1:0];

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdt_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        issue_ptr_reg <= issue_ptr_next;
        pend_addr_reg <= pend_addr_next;
        color_reg     <= color_next;
        res_reg       <= res_next;
    end

    // next state and outputs
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_ptr_next = issue_ptr_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        color_next     = color_reg;
        res_next       = res_reg;
        mem_ctl        = '0;
        mem_raddr      = issue_ptr_reg[IDX_W-1:0];
        s_ready        = 1'b0;

        case (state_reg)
            pdt_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    color_next = {s_red, s_green, s_blue};
                    case (s_mode)
                        pdt_pkg::MODE_ADD: begin
                            issue_ptr_next = '0;
                            state_next     = pdt_pkg::S_SCAN;
                        end
                        pdt_pkg::MODE_READ: begin
                            if (ridx_ext >= cnt_ext) begin
                                res_next = pdt_pkg::make_result(pdt_pkg::STAT_RANGE,
                                    8'd0, 24'd0, cnt_ext[8:0]);
                                state_next = pdt_pkg::S_DONE;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = ridx_ext[IDX_W-1:0];
                                state_next    = pdt_pkg::S_RDWAIT;
                            end
                        end
                        pdt_pkg::MODE_CLEAR: begin
                            count_next = '0;
                            res_next   = pdt_pkg::make_result(pdt_pkg::STAT_OK,
                                8'd0, 24'd0, 9'd0);
                            state_next = pdt_pkg::S_DONE;
                        end
                        default: begin
                            res_next = pdt_pkg::make_result(pdt_pkg::STAT_RANGE,
                                8'd0, 24'd0, cnt_ext[8:0]);
                            state_next = pdt_pkg::S_DONE;
                        end
                    endcase
                end
            end

            pdt_pkg::S_SCAN: begin
                // issue one read a cycle, compare the returned data in the next cycle
                mem_ctl.rd_en  = issue_more;
                pend_next      = issue_more;
                pend_addr_next = issue_ptr_reg[IDX_W-1:0];
                if (issue_more) begin
                    issue_ptr_next = issue_ptr_reg + CNT_W'(1);
                end
                if (hit) begin
                    pend_next  = 1'b0;
                    res_next   = pdt_pkg::make_result(pdt_pkg::STAT_FOUND,
                        pend_ext[7:0], 24'd0, cnt_ext[8:0]);
                    state_next = pdt_pkg::S_DONE;
                end else if (!issue_more && !pend_reg) begin
                    // no match among valid entries
                    if (count_reg == CNT_W'(DEPTH)) begin
                        res_next = pdt_pkg::make_result(pdt_pkg::STAT_FULL,
                            8'd0, 24'd0, cnt_ext[8:0]);
                    end else begin
                        mem_ctl.wr_en = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        res_next      = pdt_pkg::make_result(pdt_pkg::STAT_ADDED,
                            cnt_ext[7:0], 24'd0, cnt_inc_ext[8:0]);
                    end
                    state_next = pdt_pkg::S_DONE;
                end
            end

            pdt_pkg::S_RDWAIT: begin
                res_next   = pdt_pkg::make_result(pdt_pkg::STAT_OK,
                    8'd0, mem_rdata, cnt_ext[8:0]);
                state_next = pdt_pkg::S_DONE;
            end

            pdt_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = pdt_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = pdt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[src/palette_dedup_table_core.sv]
// Throughput: one item at a time; an add is set by the linear search through the
//   single read port of the colour store, one entry per cycle over the valid entries.
// Reset: aresetn (synchronous, active low) empties the table and drops any result;
//   the colour store itself is not cleared.
// ----------------------------------------------------------------------------
// palette_dedup_table_core
// Palette of distinct 24-bit colours in insertion order with add, read and
// clear; results leave through an output register.
// ----------------------------------------------------------------------------
module palette_dedup_table_core #(
    parameter int PALETTE_DEPTH = pdt_pkg::PALETTE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic [7:0] s_read_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_entry_index,
    output logic [7:0] m_out_red,
    output logic [7:0] m_out_green,
    output logic [7:0] m_out_blue,
    output logic [8:0] m_entry_count
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    pdt_pkg::mem_ctl_t mem_ctl;
    logic [IDX_W-1:0]  mem_raddr;
    logic [IDX_W-1:0]  mem_waddr;
    logic [23:0]       mem_wdata;
    logic [23:0]       mem_rdata;
    pdt_pkg::result_t  res;
    logic              res_valid;
    logic              res_ready;
    logic              m_valid_reg;
    pdt_pkg::result_t  m_res_reg;

    // sequencer
    pdt_seq #(
        .DEPTH (PALETTE_DEPTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_read_index (s_read_index),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_ctl      (mem_ctl),
        .mem_raddr    (mem_raddr),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata)
    );

    // colour store
    pdt_palette_ram #(
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    // result item ports
    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_entry_index = m_res_reg.entry_index;
    assign m_out_red     = m_res_reg.rgb[23:16];
    assign m_out_green   = m_res_reg.rgb[15:8];
    assign m_out_blue    = m_res_reg.rgb[7:0];
    assign m_entry_count = m_res_reg.entry_count;

endmodule

[src/pdt_checker.sv]
// ----------------------------------------------------------------------------
// pdt_checker
// Port-level checks on the result channel of the palette table.
// ----------------------------------------------------------------------------
module pdt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic [7:0] m_entry_index,
    input logic [7:0] m_out_red,
    input logic [7:0] m_out_green,
    input logic [7:0] m_out_blue,
    input logic [8:0] m_entry_count
);

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_entry_index) && $stable(m_entry_count))
        else $error("result item changed while stalled");

    // no result item right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // status code within range
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= pdt_pkg::STAT_OK)
        else $error("status code out of range");

    // index only given for added or found colours
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pdt_pkg::STAT_ADDED) && (m_status != pdt_pkg::STAT_FOUND)
            |-> m_entry_index == 8'd0)
        else $error("entry index set on a non-add result");

    // colour only given for a successful read
    a_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pdt_pkg::STAT_OK) |->
            (m_out_red == 8'd0) && (m_out_green == 8'd0) && (m_out_blue == 8'd0))
        else $error("colour bytes set on a result other than a read");

endmodule

bind palette_dedup_table_core pdt_checker u_pdt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_index (m_entry_index),
    .m_out_red     (m_out_red),
    .m_out_green   (m_out_green),
    .m_out_blue    (m_out_blue),
    .m_entry_count (m_entry_count)
);

[tb/sv/pdt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdt_tb_checker
// Watches both channels of the palette table, keeps its own copy of the
// palette to work out each result, and compares every result item field by
// field with the oldest one due.
// ----------------------------------------------------------------------------
module pdt_tb_checker #(
    parameter int DEPTH = pdt_pkg::PALETTE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic [7:0] s_read_index,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_status,
    input  logic [7:0] m_entry_index,
    input  logic [7:0] m_out_red,
    input  logic [7:0] m_out_green,
    input  logic [7:0] m_out_blue,
    input  logic [8:0] m_entry_count,
    output int         fail_count,
    output int         pending,
    output int         tbl_count
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        pdt_pkg::status_t status;
        logic [7:0]       entry_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [8:0]       entry_count;
    } palette_result_t;

    // shadow palette
    logic [23:0]     colour_mem [DEPTH];
    int unsigned     colour_count;
    palette_result_t due_results [$];

    // apply one input item to the shadow palette and return its result
    function automatic palette_result_t palette_update(logic [1:0] mode,
                                                       logic [23:0] colour,
                                                       logic [7:0] idx);
        palette_result_t res;
        int unsigned     k;
        bit              hit;
        res = '0;
        hit = 1'b0;
        case (mode)
            pdt_pkg::MODE_ADD: begin
                // lowest matching index wins
                for (k = 0; k < colour_count && !hit; k++) begin
                    if (colour_mem[k[IDX_W-1:0]] == colour) begin
                        hit = 1'b1;
                        res.status = pdt_pkg::STAT_FOUND;
                        res.entry_index = k[7:0];
                    end
                end
                if (!hit) begin
                    if (colour_count >= DEPTH) begin
                        res.status = pdt_pkg::STAT_FULL;
                    end else begin
                        colour_mem[colour_count[IDX_W-1:0]] = colour;
                        res.status = pdt_pkg::STAT_ADDED;
                        res.entry_index = colour_count[7:0];
                        colour_count++;
                    end
                end
            end
            pdt_pkg::MODE_READ: begin
                if (idx >= colour_count || idx >= DEPTH) begin
                    res.status = pdt_pkg::STAT_RANGE;
                end else begin
                    res.status = pdt_pkg::STAT_OK;
                    {res.red, res.green, res.blue} = colour_mem[IDX_W'(idx)];
                end
            end
            pdt_pkg::MODE_CLEAR: begin
                colour_count = 0;
                res.status = pdt_pkg::STAT_OK;
            end
            default: begin
                // unused mode leaves the table alone
                res.status = pdt_pkg::STAT_RANGE;
            end
        endcase
        res.entry_count = colour_count[8:0];
        return res;
    endfunction

    function automatic int field_differs(string field, int unsigned want,
                                         int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // compare result items, then record the item taken in
    always @(posedge aclk) begin
        palette_result_t want;
        int              errs;
        errs = 0;
        if (!aresetn) begin
            colour_count = 0;
            due_results.delete();
            fail_count <= 0;
            pending    <= 0;
            tbl_count  <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result item with none due, expected nothing, actual status %0d",
                             $time, m_status);
                    errs++;
                end else begin
                    want = due_results.pop_front();
                    errs += field_differs("status", 32'(want.status), 32'(m_status));
                    errs += field_differs("entry_index", 32'(want.entry_index),
                                          32'(m_entry_index));
                    errs += field_differs("out_red", 32'(want.red), 32'(m_out_red));
                    errs += field_differs("out_green", 32'(want.green), 32'(m_out_green));
                    errs += field_differs("out_blue", 32'(want.blue), 32'(m_out_blue));
                    errs += field_differs("entry_count", 32'(want.entry_count),
                                          32'(m_entry_count));
                end
            end
            if (s_valid && s_ready) begin
                due_results.insert(due_results.size(),
                                   palette_update(s_mode, {s_red, s_green, s_blue},
                                                  s_read_index));
            end
            fail_count <= fail_count + errs;
            pending    <= due_results.size();
            tbl_count  <= colour_count;
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the palette table with directed adds, reads, clears and unused
// modes, then random traffic with table fills up to full, under random
// idling and back-pressure; the checker beside the block judges the results.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          DEPTH        = pdt_pkg::PALETTE_DEPTH_DEF;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int          RANDOM_ITEMS = 1700;
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          HOLD_START   = 2500;
    localparam int          HOLD_LEN     = 500;
    localparam int          CALM_START   = 60000;
    localparam int          CALM_END     = 90000;
    localparam int          TAIL_CYCLES  = DEPTH + 40;

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode       = pdt_pkg::MODE_ADD;
    logic [7:0] s_red        = 8'd0;
    logic [7:0] s_green      = 8'd0;
    logic [7:0] s_blue       = 8'd0;
    logic [7:0] s_read_index = 8'd0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [2:0] m_status;
    logic [7:0] m_entry_index;
    logic [7:0] m_out_red;
    logic [7:0] m_out_green;
    logic [7:0] m_out_blue;
    logic [8:0] m_entry_count;

    int          fail_count;
    int          pending;
    int          tbl_count;
    int          cycle_count = 0;
    int          rx_cycle    = 0;
    int          items_sent  = 0;
    bit          no_gaps     = 1'b0;
    logic [23:0] recent_colours [16];
    logic [3:0]  recent_wr   = 4'd0;

    always #6 aclk = ~aclk;

    palette_dedup_table_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_index (m_entry_index),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_entry_count (m_entry_count)
    );

    pdt_tb_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_index (m_entry_index),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_entry_count (m_entry_count),
        .fail_count    (fail_count),
        .pending       (pending),
        .tbl_count     (tbl_count)
    );

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off and a calm stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_cycle <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
                m_ready <= 1'b0;
            end else if (rx_cycle >= CALM_START && rx_cycle < CALM_END) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 6);
            end
        end
    end

    // offer one item and hold it until taken, then maybe leave a gap
    task automatic send_item(input logic [1:0] mode, input logic [23:0] colour,
                             input logic [7:0] idx);
        bit taken;
        s_valid      <= 1'b1;
        s_mode       <= mode;
        {s_red, s_green, s_blue} <= colour;
        s_read_index <= idx;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        items_sent++;
        if (mode == pdt_pkg::MODE_ADD) begin
            recent_colours[recent_wr] = colour;
            recent_wr++;
        end
        if (!no_gaps && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // stop offering until every result item is back
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // recent colours in 40 of 100 picks so that adds hit existing entries
    function automatic logic [23:0] random_colour();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return recent_colours[4'($urandom_range(0, 15))];
        if (pick < 45) return 24'h000000;
        if (pick < 50) return 24'hFFFFFF;
        return 24'($urandom);
    endfunction

    task automatic mixed_burst(input int n);
        int          k;
        int unsigned pick;
        logic [7:0]  idx;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            idx  = 8'($urandom_range(0, 255));
            if (pick < 55) begin
                send_item(pdt_pkg::MODE_ADD, random_colour(), idx);
            end else if (pick < 95) begin
                if (tbl_count > 0 && $urandom_range(0, 9) < 7) begin
                    idx = 8'($urandom_range(0, (tbl_count > 256 ? 256 : tbl_count) - 1));
                end
                send_item(pdt_pkg::MODE_READ, 24'($urandom), idx);
            end else if (pick < 98) begin
                send_item(pdt_pkg::MODE_CLEAR, 24'($urandom), idx);
            end else begin
                send_item(MODE_UNUSED, 24'($urandom), idx);
            end
        end
    endtask

    // fill the table to the last entry, then push past full
    task automatic fill_table();
        int          k;
        logic [23:0] base;
        base = 24'($urandom);
        send_item(pdt_pkg::MODE_CLEAR, 24'($urandom), 8'($urandom));
        for (k = 0; k < DEPTH + 4; k++) begin
            send_item(pdt_pkg::MODE_ADD, 24'(base + k * 24'h010101), 8'($urandom));
            if (k > 0 && $urandom_range(0, 9) == 0) begin
                send_item(pdt_pkg::MODE_ADD,
                          24'(base + $urandom_range(0, k - 1) * 24'h010101), 8'($urandom));
            end
            if (k > 0 && $urandom_range(0, 9) == 0) begin
                send_item(pdt_pkg::MODE_READ, 24'($urandom),
                          8'($urandom_range(0, (k > 255 ? 255 : k - 1))));
            end
        end
        send_item(pdt_pkg::MODE_ADD, base, 8'($urandom));
        send_item(pdt_pkg::MODE_ADD, 24'(base + 255 * 24'h010101), 8'($urandom));
        send_item(pdt_pkg::MODE_ADD, 24'($urandom), 8'($urandom));
        send_item(pdt_pkg::MODE_READ, 24'($urandom), 8'd255);
        send_item(pdt_pkg::MODE_READ, 24'($urandom), 8'd0);
    endtask

    // stimulus and verdict
    initial begin
        int k;
        int block;
        int dir_items;
        for (k = 0; k < 16; k++) recent_colours[k] = 24'($urandom);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty reads, duplicates, range edges, unused mode, clear
        send_item(pdt_pkg::MODE_READ,  24'h000000, 8'd0);
        send_item(pdt_pkg::MODE_ADD,   24'h000000, 8'd0);
        send_item(pdt_pkg::MODE_ADD,   24'hFFFFFF, 8'hFF);
        send_item(pdt_pkg::MODE_ADD,   24'h000000, 8'd0);
        send_item(pdt_pkg::MODE_ADD,   24'hFFFFFF, 8'd0);
        send_item(pdt_pkg::MODE_ADD,   24'h800001, 8'd0);
        send_item(pdt_pkg::MODE_READ,  24'h000000, 8'd0);
        send_item(pdt_pkg::MODE_READ,  24'hFFFFFF, 8'd2);
        send_item(pdt_pkg::MODE_READ,  24'h000000, 8'd3);
        send_item(pdt_pkg::MODE_READ,  24'h000000, 8'd255);
        send_item(MODE_UNUSED,         24'hFFFFFF, 8'hFF);
        send_item(pdt_pkg::MODE_ADD,   24'hAA55AA, 8'h55);
        send_item(pdt_pkg::MODE_CLEAR, 24'h000000, 8'd0);
        send_item(pdt_pkg::MODE_READ,  24'h000000, 8'd0);
        send_item(pdt_pkg::MODE_ADD,   24'hFFFFFF, 8'd0);
        send_item(pdt_pkg::MODE_ADD,   24'h000000, 8'd0);
        send_item(pdt_pkg::MODE_READ,  24'h000000, 8'd1);
        send_item(MODE_UNUSED,         24'h000000, 8'd0);
        send_item(pdt_pkg::MODE_CLEAR, 24'hFFFFFF, 8'hFF);
        drain();
        dir_items = items_sent;

        // random: mixed bursts with two complete fills
        block = 0;
        while (items_sent < dir_items + RANDOM_ITEMS) begin
            block++;
            no_gaps = (block >= 3 && block <= 5);
            if (block == 1 || block == 14) fill_table();
            else mixed_burst(50);
            if (block == 7) drain();
        end
        no_gaps = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
